@@ hw/rtl/dhs_pkg.sv @@
// Package for the double hash set core: default sizes, field widths,
// command and status codes, and state types. No dependencies.
package dhs_pkg;

    localparam int TABLE_SIZE_DEF    = 97;
    localparam int STEP_PRIME_DEF    = 89;
    localparam int ELEMENT_BYTES_DEF = 4;

    localparam int ELEM_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int SLOT_OUT_W   = 7;
    localparam int PROBES_OUT_W = 7;
    localparam int OUT_TDATA_W  = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        H_IDLE,
        H_QUOT,
        H_REM,
        H_FIX,
        H_TQUOT,
        H_TREM,
        H_DONE
    } t_hash_state;

endpackage

@@ hw/rtl/dhs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module dhs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 97
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/dhs_hash.sv @@
// Hash unit: forms the signed byte key of an element and reduces it by
// reciprocal multiplication to the home slot and the probe step. Depends on dhs_pkg.
module dhs_hash import dhs_pkg::*; #(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int STEP_PRIME    = STEP_PRIME_DEF,
    parameter int ELEMENT_BYTES = ELEMENT_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ELEM_W-1:0]             i_element,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_h1,
    output logic [$clog2(TABLE_SIZE)-1:0] o_step
);

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int STEP_W  = $clog2(STEP_PRIME + 1);
    localparam int MAG_W   = 8 + ELEMENT_BYTES;
    localparam int KEY_W   = MAG_W + 1;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int TPROD_W = 2 * STEP_W + SLOT_W + 1;

    localparam logic [63:0] ALL1_M   = 64'hFFFF_FFFF_FFFF_FFFF % TABLE_SIZE;
    localparam logic [63:0] ALL1_S   = 64'hFFFF_FFFF_FFFF_FFFF % STEP_PRIME;
    localparam logic [63:0] WRAP_M64 = (ALL1_M + 64'd1) % TABLE_SIZE;
    localparam logic [63:0] WRAP_S64 = (ALL1_S + 64'd1) % STEP_PRIME;

    localparam logic [PROD_W-1:0]  RECIP_M = PROD_W'((64'd1 << MAG_W) / TABLE_SIZE);
    localparam logic [PROD_W-1:0]  RECIP_S = PROD_W'((64'd1 << MAG_W) / STEP_PRIME);
    localparam logic [TPROD_W-1:0] RECIP_T = TPROD_W'((64'd1 << STEP_W) / TABLE_SIZE);
    localparam logic [PROD_W-1:0]  MUL_M   = PROD_W'(TABLE_SIZE);
    localparam logic [PROD_W-1:0]  MUL_S   = PROD_W'(STEP_PRIME);
    localparam logic [TPROD_W-1:0] MUL_T   = TPROD_W'(TABLE_SIZE);

    localparam logic [SLOT_W:0] MOD_M  = (SLOT_W+1)'(TABLE_SIZE);
    localparam logic [STEP_W:0] MOD_S  = (STEP_W+1)'(STEP_PRIME);
    localparam logic [SLOT_W:0] WRAP_M = WRAP_M64[SLOT_W:0];
    localparam logic [STEP_W:0] WRAP_S = WRAP_S64[STEP_W:0];

    t_hash_state r_state, n_state;

    logic [MAG_W-1:0]  r_mag;
    logic              r_neg;
    logic [MAG_W-1:0]  r_qm;
    logic [MAG_W-1:0]  r_qs;
    logic [SLOT_W-1:0] r_rm;
    logic [STEP_W-1:0] r_rs;
    logic [STEP_W-1:0] r_h2;
    logic [STEP_W-1:0] r_qt;
    logic [SLOT_W-1:0] r_rt;

    logic [63:0]             v_elem64;
    logic [7:0]              v_byte;
    logic signed [KEY_W-1:0] v_term;
    logic signed [KEY_W-1:0] v_key;
    logic [KEY_W-1:0]        v_neg_key;
    logic [MAG_W-1:0]        v_mag;

    logic [PROD_W-1:0]  v_prod_m, v_prod_s;
    logic [PROD_W-1:0]  v_diff_m, v_diff_s;
    logic [TPROD_W-1:0] v_prod_t, v_diff_t;
    logic [SLOT_W:0]    v_rm_raw, v_rm_red;
    logic [STEP_W:0]    v_rs_raw, v_rs_red;
    logic [SLOT_W:0]    v_rt_raw, v_rt_red;
    logic [SLOT_W:0]    v_h1_fix;
    logic [STEP_W:0]    v_ks_fix;
    logic [STEP_W:0]    v_h2;

    // key over the bytes, low byte first, bytes above the word count as zero
    always_comb begin
        v_elem64 = {32'd0, i_element};
        v_key    = '0;
        v_byte   = '0;
        v_term   = '0;
        for (int n = 0; n < ELEMENT_BYTES; n++) begin
            v_byte = v_elem64[8*n +: 8];
            v_term = KEY_W'($signed(v_byte)) + KEY_W'(5);
            v_key  = v_key + (v_term <<< (ELEMENT_BYTES - 1 - n));
        end
        v_neg_key = -v_key;
        v_mag     = v_key[KEY_W-1] ? v_neg_key[MAG_W-1:0] : v_key[MAG_W-1:0];
    end

    // quotient estimate is exact or one low; one compare and subtract corrects it
    always_comb begin
        v_prod_m = PROD_W'(r_mag) * RECIP_M;
        v_prod_s = PROD_W'(r_mag) * RECIP_S;
        v_diff_m = PROD_W'(r_mag) - PROD_W'(r_qm) * MUL_M;
        v_diff_s = PROD_W'(r_mag) - PROD_W'(r_qs) * MUL_S;
        v_rm_raw = v_diff_m[SLOT_W:0];
        v_rm_red = (v_rm_raw >= MOD_M) ? v_rm_raw - MOD_M : v_rm_raw;
        v_rs_raw = v_diff_s[STEP_W:0];
        v_rs_red = (v_rs_raw >= MOD_S) ? v_rs_raw - MOD_S : v_rs_raw;

        v_prod_t = TPROD_W'(r_h2) * RECIP_T;
        v_diff_t = TPROD_W'(r_h2) - TPROD_W'(r_qt) * MUL_T;
        v_rt_raw = v_diff_t[SLOT_W:0];
        v_rt_red = (v_rt_raw >= MOD_M) ? v_rt_raw - MOD_M : v_rt_raw;

        // negative keys wrap through 2^64
        if (!r_neg) begin
            v_h1_fix = {1'b0, r_rm};
            v_ks_fix = {1'b0, r_rs};
        end else begin
            v_h1_fix = ({1'b0, r_rm} <= WRAP_M) ? WRAP_M - {1'b0, r_rm}
                                                : WRAP_M + MOD_M - {1'b0, r_rm};
            v_ks_fix = ({1'b0, r_rs} <= WRAP_S) ? WRAP_S - {1'b0, r_rs}
                                                : WRAP_S + MOD_S - {1'b0, r_rs};
        end
        v_h2 = MOD_S - v_ks_fix;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: begin
                if (i_start) n_state = H_QUOT;
            end
            H_QUOT: begin
                n_state = H_REM;
            end
            H_REM: begin
                n_state = H_FIX;
            end
            H_FIX: begin
                n_state = H_TQUOT;
            end
            H_TQUOT: begin
                n_state = H_TREM;
            end
            H_TREM: begin
                n_state = H_DONE;
            end
            H_DONE: begin
                n_state = H_IDLE;
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == H_DONE);
        o_h1   = r_rm;
        o_step = r_rt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    r_mag <= v_mag;
                    r_neg <= v_key[KEY_W-1];
                end
            end
            H_QUOT: begin
                r_qm <= v_prod_m[MAG_W +: MAG_W];
                r_qs <= v_prod_s[MAG_W +: MAG_W];
            end
            H_REM: begin
                r_rm <= v_rm_red[SLOT_W-1:0];
                r_rs <= v_rs_red[STEP_W-1:0];
            end
            H_FIX: begin
                r_rm <= v_h1_fix[SLOT_W-1:0];
                r_h2 <= v_h2[STEP_W-1:0];
            end
            H_TQUOT: begin
                r_qt <= v_prod_t[STEP_W +: STEP_W];
            end
            H_TREM: begin
                r_rt <= v_rt_red[SLOT_W-1:0];
            end
            H_DONE: begin
                r_rt <= r_rt;
            end
            default: begin
                r_rt <= r_rt;
            end
        endcase
    end

endmodule

@@ hw/rtl/double_hash_set_core.sv @@
// Double hash set core: open-addressed table of elements in one RAM,
// probed with double hashing. Depends on dhs_pkg, dhs_hash and dhs_ram.
//
//   Channel | Direction | Signals                   | Contents
//   --------+-----------+---------------------------+---------------------------------
//   s       | in        | i_s_tvalid / o_s_tready   | tuser: command; tdata: element
//   m       | out       | o_m_tvalid / i_m_tready   | tuser: status; tdata: slot, probes
//
// One transaction at a time. The result is valid after five hash steps, one hand-off,
// one RAM read, one compare per probe and one output load. The next request is taken
// only after that output load, so transactions never overlap.
// After reset a clearing pass writes every RAM slot empty; no request
// is taken meanwhile. A result waiting on the m side stalls only the final step.
module double_hash_set_core import dhs_pkg::*; #(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int STEP_PRIME    = STEP_PRIME_DEF,
    parameter int ELEMENT_BYTES = ELEMENT_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [ELEM_W-1:0]      i_s_tdata,   // [31:0] element
    input  logic                   i_s_tuser,   // [0] command
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [6:0] slot, [13:7] probes, [15:14] zero
    output logic [STATUS_W-1:0]    o_m_tuser    // [1:0] status
);

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int PROBE_W = $clog2(TABLE_SIZE + 1);
    localparam int ENTRY_W = ELEM_W + 1;

    localparam logic [63:0]       MASK64    = (64'd1 << (8 * ELEMENT_BYTES)) - 64'd1;
    localparam logic [ELEM_W-1:0] ELEM_MASK = (ELEMENT_BYTES >= 4) ? '1 : MASK64[ELEM_W-1:0];
    localparam logic [SLOT_W:0]   MOD_M     = (SLOT_W+1)'(TABLE_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(TABLE_SIZE - 1);

    t_state r_state, n_state;

    logic              r_cmd;
    logic [ELEM_W-1:0] r_elem;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_step;
    logic [SLOT_W-1:0] r_eval_idx;
    logic              r_rd_valid;
    logic [PROBE_W-1:0] r_cnt;
    logic [SLOT_W-1:0] r_clr_addr;

    t_status            r_res_status;
    logic [SLOT_W-1:0]  r_res_slot;
    logic [PROBE_W-1:0] r_res_probes;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [SLOT_OUT_W-1:0]   r_out_slot;
    logic [PROBES_OUT_W-1:0] r_out_probes;

    logic s_accept;
    logic out_load;

    logic              hash_done;
    logic [SLOT_W-1:0] hash_h1;
    logic [SLOT_W-1:0] hash_step;

    logic               ram_wr_en;
    logic [SLOT_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic               v_filled;
    logic               v_match;
    logic               v_hit;
    logic               v_finish;
    t_status            v_status;
    logic [SLOT_W-1:0]  v_slot;
    logic [PROBE_W-1:0] v_probes;
    logic [SLOT_W:0]    v_sum;
    logic [SLOT_W-1:0]  v_next_idx;
    logic [31:0]        v_slot32;
    logic [31:0]        v_probes32;

    dhs_hash #(
        .TABLE_SIZE    (TABLE_SIZE),
        .STEP_PRIME    (STEP_PRIME),
        .ELEMENT_BYTES (ELEMENT_BYTES)
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_accept),
        .i_element (i_s_tdata & ELEM_MASK),
        .o_done    (hash_done),
        .o_h1      (hash_h1),
        .o_step    (hash_step)
    );

    dhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    // evaluate the slot read in the previous cycle
    always_comb begin
        v_filled = ram_rd_data[ELEM_W];
        v_match  = (ram_rd_data[ELEM_W-1:0] == r_elem);
        v_hit    = 1'b0;
        v_status = (r_cmd == CMD_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
        v_slot   = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (!v_filled) begin
                    v_hit    = 1'b1;
                    v_status = STATUS_INSERTED;
                    v_slot   = r_eval_idx;
                end
            end
            CMD_LOOKUP: begin
                if (!v_filled) begin
                    v_hit    = 1'b1;
                    v_status = STATUS_NOT_FOUND;
                end else if (v_match) begin
                    v_hit    = 1'b1;
                    v_status = STATUS_FOUND;
                    v_slot   = r_eval_idx;
                end
            end
            default: v_hit = 1'b0;
        endcase
        v_probes = r_cnt + 1'b1;
        v_finish = (r_state == S_PROBE) && r_rd_valid && (v_hit || (r_cnt == LAST_PROBE));

        v_sum      = {1'b0, r_idx} + {1'b0, r_step};
        v_next_idx = (v_sum >= MOD_M) ? SLOT_W'(v_sum - MOD_M) : v_sum[SLOT_W-1:0];

        v_slot32   = 32'(r_res_slot);
        v_probes32 = 32'(r_res_probes);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_SLOT) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_accept) n_state = S_HASH;
            end
            S_HASH: begin
                if (hash_done) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (v_finish) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_s_tready  = (r_state == S_IDLE);
        s_accept    = i_s_tvalid && (r_state == S_IDLE);
        out_load    = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
        ram_rd_en   = (r_state == S_PROBE);
        ram_wr_en   = (r_state == S_CLEAR) ||
                      ((r_state == S_PROBE) && r_rd_valid && (r_cmd == CMD_INSERT) && !v_filled);
        ram_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_eval_idx;
        ram_wr_data = (r_state == S_CLEAR) ? '0 : {1'b1, r_elem};
        o_m_tvalid  = r_out_valid;
        o_m_tuser   = r_out_status;
        o_m_tdata   = {2'b00, r_out_probes, r_out_slot};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_PROBE && !v_finish) begin
                r_rd_valid <= 1'b1;
            end else begin
                r_rd_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd  <= i_s_tuser;
            r_elem <= i_s_tdata & ELEM_MASK;
        end
        if (r_state == S_HASH && hash_done) begin
            r_idx  <= hash_h1;
            r_step <= hash_step;
            r_cnt  <= '0;
        end
        if (r_state == S_PROBE) begin
            r_idx      <= v_next_idx;
            r_eval_idx <= r_idx;
            if (r_rd_valid && !v_finish) begin
                r_cnt <= v_probes;
            end
        end
        if (v_finish) begin
            r_res_status <= v_status;
            r_res_slot   <= v_slot;
            r_res_probes <= v_probes;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= v_slot32[SLOT_OUT_W-1:0];
            r_out_probes <= v_probes32[PROBES_OUT_W-1:0];
        end
    end

endmodule
